// ===== src/tmsa_pkg.sv =====
// Shared types and constants for the trimmed mean sample averager.
// No dependencies; used by every module of the block.
package tmsa_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 8;
  localparam int SUM_BITS    = 32;
  localparam int TRIM_BITS   = SUM_BITS + 2;
  localparam int STEP_BITS   = $clog2(TRIM_BITS);
  localparam int IN_BYTES    = (SAMPLE_BITS + 7) / 8;
  localparam int OUT_BYTES   = (2 * SAMPLE_BITS + 7) / 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_BITS-1:0] MIN_COUNT = COUNT_BITS'(3);
  localparam logic [COUNT_BITS-1:0] TRIM      = COUNT_BITS'(2);

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef struct packed {
    logic signed [SUM_BITS-1:0]    sum;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic signed [SAMPLE_BITS-1:0] lo;
    logic [COUNT_BITS-1:0]         taken;
  } blk_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ABS,
    BK_DIV,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic absolute;
    logic step;
    logic finish;
  } back_ctrl_t;

endpackage

// ===== src/tmsa_front.sv =====
// Front part: sample accumulation, max/min tracking, block count, count register.
// Depends on tmsa_pkg; pushes finished blocks into tmsa_queue.
module tmsa_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tmsa_pkg::COUNT_BITS-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic signed [tmsa_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                 full,
  output logic                                 push,
  output tmsa_pkg::blk_t                       push_data
);

  logic [tmsa_pkg::COUNT_BITS-1:0]         count_r;
  logic signed [tmsa_pkg::SUM_BITS-1:0]    sum_r;
  logic signed [tmsa_pkg::SAMPLE_BITS-1:0] hi_r;
  logic signed [tmsa_pkg::SAMPLE_BITS-1:0] lo_r;
  logic [tmsa_pkg::COUNT_BITS-1:0]         taken_r;

  logic signed [tmsa_pkg::SUM_BITS-1:0]    sum_nxt;
  logic signed [tmsa_pkg::SAMPLE_BITS-1:0] hi_nxt;
  logic signed [tmsa_pkg::SAMPLE_BITS-1:0] lo_nxt;
  logic [tmsa_pkg::COUNT_BITS-1:0]         taken_nxt;
  logic                                    accept;
  logic                                    done;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  assign sum_nxt   = sum_r + {{(tmsa_pkg::SUM_BITS-tmsa_pkg::SAMPLE_BITS){sample[
                       tmsa_pkg::SAMPLE_BITS-1]}}, sample};
  assign hi_nxt    = (sample > hi_r) ? sample : hi_r;
  assign lo_nxt    = (sample < lo_r) ? sample : lo_r;
  assign taken_nxt = taken_r + tmsa_pkg::COUNT_BITS'(1);
  assign done      = (taken_nxt >= count_r);

  assign push            = accept && done;
  assign push_data.sum   = sum_nxt;
  assign push_data.hi    = hi_nxt;
  assign push_data.lo    = lo_nxt;
  assign push_data.taken = taken_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= tmsa_pkg::MIN_COUNT;
    end else if (cfg_we) begin
      count_r <= (cfg_wdata < tmsa_pkg::MIN_COUNT) ? tmsa_pkg::MIN_COUNT : cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      hi_r    <= tmsa_pkg::SAMPLE_MIN;
      lo_r    <= tmsa_pkg::SAMPLE_MAX;
      taken_r <= '0;
    end else if (accept) begin
      if (done) begin
        sum_r   <= '0;
        hi_r    <= tmsa_pkg::SAMPLE_MIN;
        lo_r    <= tmsa_pkg::SAMPLE_MAX;
        taken_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        hi_r    <= hi_nxt;
        lo_r    <= lo_nxt;
        taken_r <= taken_nxt;
      end
    end
  end

endmodule

// ===== src/tmsa_queue.sv =====
// Two-entry queue of finished blocks between the front and the back part.
// Depends on tmsa_pkg for the entry type.
module tmsa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tmsa_pkg::blk_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output tmsa_pkg::blk_t q_data
);

  tmsa_pkg::blk_t                   mem [tmsa_pkg::QUEUE_DEPTH];
  logic [tmsa_pkg::QPTR_BITS-1:0]   wr_ptr_r;
  logic [tmsa_pkg::QPTR_BITS-1:0]   rd_ptr_r;
  logic [tmsa_pkg::QPTR_BITS:0]     fill_r;

  assign full    = (fill_r == (tmsa_pkg::QPTR_BITS+1)'(tmsa_pkg::QUEUE_DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + tmsa_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + tmsa_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + (tmsa_pkg::QPTR_BITS+1)'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - (tmsa_pkg::QPTR_BITS+1)'(1);
      end
    end
  end

endmodule

// ===== src/tmsa_back.sv =====
// Back part: trim, signed divide one quotient bit per cycle, output register.
// Depends on tmsa_pkg; pops blocks from tmsa_queue.
module tmsa_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  tmsa_pkg::blk_t                      q_data,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tmsa_pkg::SAMPLE_BITS-1:0]    average,
  output logic [tmsa_pkg::SAMPLE_BITS-1:0]    spread
);

  localparam int XB = tmsa_pkg::TRIM_BITS - tmsa_pkg::SAMPLE_BITS;
  localparam int XS = tmsa_pkg::TRIM_BITS - tmsa_pkg::SUM_BITS;

  tmsa_pkg::back_state_t state_r, state_nxt;
  tmsa_pkg::back_ctrl_t  ctrl;

  logic [tmsa_pkg::TRIM_BITS-1:0]   quo_r;
  logic [tmsa_pkg::COUNT_BITS-1:0]  rem_r;
  logic [tmsa_pkg::COUNT_BITS-1:0]  div_r;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] spread_r;
  logic                             neg_r;
  logic [tmsa_pkg::STEP_BITS-1:0]   step_r;
  logic                             out_valid_r;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] avg_out_r;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] spread_out_r;

  logic [tmsa_pkg::TRIM_BITS-1:0]   trimmed;
  logic [tmsa_pkg::COUNT_BITS:0]    rem_sh;
  logic [tmsa_pkg::COUNT_BITS:0]    diff;
  logic                             qbit;
  logic [tmsa_pkg::TRIM_BITS-1:0]   quotient;
  logic                             out_free;

  assign trimmed = {{XS{q_data.sum[tmsa_pkg::SUM_BITS-1]}}, q_data.sum}
                 - {{XB{q_data.hi[tmsa_pkg::SAMPLE_BITS-1]}}, q_data.hi}
                 - {{XB{q_data.lo[tmsa_pkg::SAMPLE_BITS-1]}}, q_data.lo};

  assign rem_sh   = {rem_r, quo_r[tmsa_pkg::TRIM_BITS-1]};
  assign diff     = rem_sh - {1'b0, div_r};
  assign qbit     = !diff[tmsa_pkg::COUNT_BITS];
  assign quotient = neg_r ? (~quo_r + tmsa_pkg::TRIM_BITS'(1)) : quo_r;
  assign out_free = !out_valid_r || out_tready;

  assign pop        = ctrl.pop;
  assign out_tvalid = out_valid_r;
  assign average    = avg_out_r;
  assign spread     = spread_out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmsa_pkg::BK_IDLE: if (q_valid) state_nxt = tmsa_pkg::BK_ABS;
      tmsa_pkg::BK_ABS:  state_nxt = tmsa_pkg::BK_DIV;
      tmsa_pkg::BK_DIV:  if (step_r == '0) state_nxt = tmsa_pkg::BK_FIN;
      tmsa_pkg::BK_FIN:  if (out_free) state_nxt = tmsa_pkg::BK_IDLE;
      default:           state_nxt = tmsa_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      tmsa_pkg::BK_IDLE: ctrl.pop      = q_valid;
      tmsa_pkg::BK_ABS:  ctrl.absolute = 1'b1;
      tmsa_pkg::BK_DIV:  ctrl.step     = 1'b1;
      tmsa_pkg::BK_FIN:  ctrl.finish   = out_free;
      default:           ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmsa_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      quo_r    <= trimmed;
      neg_r    <= trimmed[tmsa_pkg::TRIM_BITS-1];
      div_r    <= q_data.taken - tmsa_pkg::TRIM;
      spread_r <= q_data.hi - q_data.lo;
    end
    if (ctrl.absolute) begin
      if (neg_r) begin
        quo_r <= ~quo_r + tmsa_pkg::TRIM_BITS'(1);
      end
      rem_r  <= '0;
      step_r <= tmsa_pkg::STEP_BITS'(tmsa_pkg::TRIM_BITS - 1);
    end
    if (ctrl.step) begin
      quo_r  <= {quo_r[tmsa_pkg::TRIM_BITS-2:0], qbit};
      rem_r  <= qbit ? diff[tmsa_pkg::COUNT_BITS-1:0] : rem_sh[tmsa_pkg::COUNT_BITS-1:0];
      step_r <= step_r - tmsa_pkg::STEP_BITS'(1);
    end
    if (ctrl.finish) begin
      avg_out_r    <= quotient[tmsa_pkg::SAMPLE_BITS-1:0];
      spread_out_r <= spread_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== src/trimmed_mean_sample_averager_top.sv =====
// Trimmed mean sample averager: drops one max and one min per block, divides by its samples - 2.
// Takes one item per cycle; the queue stalls input only when two blocks wait on the divider.
// A block's result passes the queue, the pop with trim, the absolute step, the 34-step
// divider and the output register; a new block is popped only once that result is loaded.
// Synchronous active-low reset: count 3, empty block, empty queue, no result pending.
// Depends on tmsa_pkg, tmsa_front, tmsa_queue, tmsa_back.
module trimmed_mean_sample_averager_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tmsa_pkg::COUNT_BITS-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tmsa_pkg::IN_BYTES*8-1:0]   in_tdata,   // [23:0] sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tmsa_pkg::OUT_BYTES*8-1:0]  out_tdata   // [23:0] average, [47:24] spread
);

  tmsa_pkg::blk_t                   push_data;
  tmsa_pkg::blk_t                   q_data;
  logic                             push;
  logic                             full;
  logic                             pop;
  logic                             q_valid;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] average;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] spread;

  tmsa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sample    (in_tdata[tmsa_pkg::SAMPLE_BITS-1:0]),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  tmsa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  tmsa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .average    (average),
    .spread     (spread)
  );

  assign out_tdata = {{(tmsa_pkg::OUT_BYTES*8 - 2*tmsa_pkg::SAMPLE_BITS){1'b0}},
                      spread, average};

endmodule

// ===== tb/trimmed_mean_sample_averager_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for trimmed_mean_sample_averager_top: streams signed samples,
// predicts each block's trimmed mean and spread, and compares every result item.
// Depends on tmsa_pkg and the trimmed_mean_sample_averager_top RTL.
module trimmed_mean_sample_averager_top_test;

  localparam int ITEM_TARGET   = 1100;
  localparam int CALM_AFTER    = 850;
  localparam int SETTLE_CYCLES = 48;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic signed [tmsa_pkg::SAMPLE_BITS-1:0] average;
    logic [tmsa_pkg::SAMPLE_BITS-1:0]        spread;
  } block_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 cfg_we = 1'b0;
  logic [tmsa_pkg::COUNT_BITS-1:0]      cfg_wdata = '0;
  logic                                 in_tvalid = 1'b0;
  logic                                 in_tready;
  logic [tmsa_pkg::IN_BYTES*8-1:0]      in_tdata = '0;   // [23:0] sample
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic [tmsa_pkg::OUT_BYTES*8-1:0]     out_tdata;       // [23:0] average, [47:24] spread

  logic [tmsa_pkg::SAMPLE_BITS-1:0]     samples_to_send[$];
  block_result_t                        awaited_results[$];
  block_result_t                        head_result;

  logic [31:0]                          acc_sum;
  logic signed [tmsa_pkg::SAMPLE_BITS-1:0] acc_hi;
  logic signed [tmsa_pkg::SAMPLE_BITS-1:0] acc_lo;
  logic [tmsa_pkg::COUNT_BITS-1:0]      acc_taken;
  logic [tmsa_pkg::COUNT_BITS-1:0]      block_len;

  int  errors = 0;
  int  queued_total = 0;
  int  samples_taken_in = 0;
  int  blocks_checked = 0;
  int  len_lo = 255;
  int  len_hi = 0;
  int  in_gap = 0;
  int  stall_left = 0;
  int  holds_asked = 0;
  int  holds_granted = 0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;

  trimmed_mean_sample_averager_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_block_state();
    acc_sum   = '0;
    acc_hi    = tmsa_pkg::SAMPLE_MIN;
    acc_lo    = tmsa_pkg::SAMPLE_MAX;
    acc_taken = '0;
  endfunction

  function automatic void set_block_len(logic [tmsa_pkg::COUNT_BITS-1:0] raw);
    block_len = (raw < tmsa_pkg::MIN_COUNT) ? tmsa_pkg::MIN_COUNT : raw;
  endfunction

  function automatic void fold_sample(logic signed [tmsa_pkg::SAMPLE_BITS-1:0] s);
    longint        trimmed;
    longint        quotient;
    longint        range;
    block_result_t r;
    acc_sum = acc_sum + {{(32-tmsa_pkg::SAMPLE_BITS){s[tmsa_pkg::SAMPLE_BITS-1]}}, s};
    if (s > acc_hi) acc_hi = s;
    if (s < acc_lo) acc_lo = s;
    acc_taken = acc_taken + tmsa_pkg::COUNT_BITS'(1);
    if (acc_taken >= block_len) begin
      trimmed   = longint'($signed(acc_sum)) - longint'(acc_hi) - longint'(acc_lo);
      quotient  = trimmed / longint'(acc_taken - tmsa_pkg::TRIM);
      range     = longint'(acc_hi) - longint'(acc_lo);
      r.average = quotient[tmsa_pkg::SAMPLE_BITS-1:0];
      r.spread  = range[tmsa_pkg::SAMPLE_BITS-1:0];
      awaited_results.push_back(r);
      clear_block_state();
    end
  endfunction

  function automatic logic [tmsa_pkg::SAMPLE_BITS-1:0] draw_sample(int base);
    case ($urandom_range(0, 9))
      0:       return tmsa_pkg::SAMPLE_MIN;
      1:       return tmsa_pkg::SAMPLE_MAX;
      2, 3:    return tmsa_pkg::SAMPLE_BITS'($urandom());
      4:       return tmsa_pkg::SAMPLE_BITS'(int'($urandom_range(0, 600)) - 300);
      default: return tmsa_pkg::SAMPLE_BITS'(base + int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic queue_sample(input logic [tmsa_pkg::SAMPLE_BITS-1:0] s);
    samples_to_send.push_back(s);
    queued_total++;
  endtask

  task automatic wait_quiet();
    while (samples_to_send.size() != 0 || in_tvalid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [tmsa_pkg::COUNT_BITS-1:0] raw);
    int eff;
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= raw;
    @(posedge clk);
    cfg_we    <= 1'b0;
    eff = (raw < tmsa_pkg::MIN_COUNT) ? int'(tmsa_pkg::MIN_COUNT) : int'(raw);
    if (eff < len_lo) len_lo = eff;
    if (eff > len_hi) len_hi = eff;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (samples_to_send.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (in_idle_on && $urandom_range(0, 7) == 0) begin
        in_gap    <= $urandom_range(0, 16);
        in_tvalid <= 1'b0;
      end else begin
        in_tdata  <= samples_to_send.pop_front();
        in_tvalid <= 1'b1;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      stall_left    <= LONG_HOLD;
      out_tready    <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_block_state();
      block_len = tmsa_pkg::MIN_COUNT;
    end else begin
      if (cfg_we) set_block_len(cfg_wdata);
      if (in_tvalid && in_tready) begin
        fold_sample(in_tdata[tmsa_pkg::SAMPLE_BITS-1:0]);
        samples_taken_in++;
      end
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected item average=%0d spread=%0d", $time,
                   $signed(out_tdata[tmsa_pkg::SAMPLE_BITS-1:0]),
                   out_tdata[2*tmsa_pkg::SAMPLE_BITS-1:tmsa_pkg::SAMPLE_BITS]);
        end else begin
          head_result = awaited_results.pop_front();
          blocks_checked++;
          if (out_tdata[tmsa_pkg::SAMPLE_BITS-1:0] !== head_result.average) begin
            errors++;
            $display("%0t: average expected %0d got %0d", $time, head_result.average,
                     $signed(out_tdata[tmsa_pkg::SAMPLE_BITS-1:0]));
          end
          if (out_tdata[2*tmsa_pkg::SAMPLE_BITS-1:tmsa_pkg::SAMPLE_BITS]
              !== head_result.spread) begin
            errors++;
            $display("%0t: spread expected %0d got %0d", $time, head_result.spread,
                     out_tdata[2*tmsa_pkg::SAMPLE_BITS-1:tmsa_pkg::SAMPLE_BITS]);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int phase;
    int raw;
    int len;
    int blocks;
    int total;
    int base;
    int guard;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_count(8'd0);
    queue_sample(tmsa_pkg::SAMPLE_MAX);
    queue_sample(tmsa_pkg::SAMPLE_MIN);
    queue_sample(tmsa_pkg::SAMPLE_BITS'(0));
    write_count(8'd1);
    repeat (3) queue_sample(tmsa_pkg::SAMPLE_MIN);
    write_count(8'd2);
    repeat (3) queue_sample(tmsa_pkg::SAMPLE_MAX);
    queue_sample(tmsa_pkg::SAMPLE_BITS'(-1));
    queue_sample(tmsa_pkg::SAMPLE_BITS'(-2));
    queue_sample(tmsa_pkg::SAMPLE_BITS'(-4));
    write_count(8'd5);
    queue_sample(tmsa_pkg::SAMPLE_BITS'(-1));
    queue_sample(tmsa_pkg::SAMPLE_BITS'(-1));
    queue_sample(tmsa_pkg::SAMPLE_BITS'(-2));
    queue_sample(tmsa_pkg::SAMPLE_BITS'(0));
    queue_sample(tmsa_pkg::SAMPLE_BITS'(0));
    // shrink the count under a half-filled block
    write_count(8'd10);
    queue_sample(tmsa_pkg::SAMPLE_BITS'(100));
    queue_sample(tmsa_pkg::SAMPLE_BITS'(-50));
    queue_sample(tmsa_pkg::SAMPLE_BITS'(7));
    queue_sample(tmsa_pkg::SAMPLE_BITS'(8));
    queue_sample(tmsa_pkg::SAMPLE_BITS'(-9));
    queue_sample(tmsa_pkg::SAMPLE_BITS'(1000));
    write_count(8'd4);
    queue_sample(tmsa_pkg::SAMPLE_BITS'(-333));

    phase = 0;
    while (queued_total < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       raw = $urandom_range(0, 255);
        1:       raw = 255;
        default: raw = $urandom_range(3, 12);
      endcase
      if (phase == 1) raw = 255;
      if (phase == 2) raw = int'(tmsa_pkg::MIN_COUNT);
      write_count(raw[tmsa_pkg::COUNT_BITS-1:0]);
      in_idle_on  <= (queued_total < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      out_idle_on <= (queued_total < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      len    = (raw < int'(tmsa_pkg::MIN_COUNT)) ? int'(tmsa_pkg::MIN_COUNT) : raw;
      blocks = (len > 20) ? 1 : $urandom_range(1, 8);
      if (phase == 2) begin
        blocks = 20;
        holds_asked++;
      end
      total = len * blocks;
      if ($urandom_range(0, 2) == 0) total += $urandom_range(0, len - 1);
      if (total > ITEM_TARGET - queued_total) total = ITEM_TARGET - queued_total;
      base = $urandom_range(0, 1 << 23) - (1 << 22);
      repeat (total) queue_sample(draw_sample(base));
      phase++;
    end

    while (samples_to_send.size() != 0 || in_tvalid) @(posedge clk);
    guard = 0;
    while (awaited_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
    end
    $display("Sent %0d samples in %0d phases; checked %0d averaged blocks", samples_taken_in,
             phase, blocks_checked);
    $display("Block lengths ranged %0d to %0d; %0d mismatches", len_lo, len_hi, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
